[rtl/drs_pkg.sv]
// delivery rate sampler: shared constants, word types and slot layout
// no dependencies
package drs_pkg;

	localparam int TRACK_DEPTH = 256;
	localparam int SLOT_BITS   = $clog2(TRACK_DEPTH);
	localparam int TIME_BITS   = 48;
	localparam int NUM_BITS    = 48;
	localparam int BYTE_BITS   = 48;
	localparam int SIZE_BITS   = 16;
	localparam int FLIGHT_BITS = 32;
	localparam int RATE_BITS   = 64;
	localparam int MULT_BITS   = 14;
	localparam int PROD_BITS   = BYTE_BITS + MULT_BITS;
	localparam int RATE_SHIFT  = 9;
	localparam int DIVD_BITS   = PROD_BITS + RATE_SHIFT;
	localparam int CNT_BITS    = $clog2(RATE_BITS);

	// 8e6 = 15625 << 9
	localparam logic [MULT_BITS-1:0] BIT_RATE_MULT = 14'd15625;
	localparam logic [RATE_BITS-1:0] RATE_INF = '1;
	localparam logic [RATE_BITS-1:0] RATE_MAX = {{(RATE_BITS-1){1'b1}}, 1'b0};

	localparam logic [2:0] OP_SENT  = 3'd0;
	localparam logic [2:0] OP_ACKED = 3'd1;
	localparam logic [2:0] OP_LOST  = 3'd2;
	localparam logic [2:0] OP_APP   = 3'd3;
	localparam logic [2:0] OP_DROP  = 3'd4;

	typedef struct packed {
		logic [2:0]             operation;
		logic [TIME_BITS-1:0]   event_time;
		logic [NUM_BITS-1:0]    pkt_num;
		logic [SIZE_BITS-1:0]   packet_bytes;
		logic [FLIGHT_BITS-1:0] flight_bytes;
	} drs_in_t;

	typedef struct packed {
		logic                 sample_valid;
		logic [RATE_BITS-1:0] bandwidth_bps;
		logic [TIME_BITS-1:0] rtt_us;
		logic                 sample_app_limited;
		logic [BYTE_BITS-1:0] total_acked;
		logic                 app_limited_now;
		logic [NUM_BITS-1:0]  app_limited_end;
		logic                 refused;
	} drs_out_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] tx_time;
		logic [SIZE_BITS-1:0] size;
		logic [BYTE_BITS-1:0] bytes_sent;
		logic [BYTE_BITS-1:0] bytes_sent_prev;
		logic [TIME_BITS-1:0] prev_sent_time;
		logic [TIME_BITS-1:0] prev_ack_time;
		logic [BYTE_BITS-1:0] bytes_acked_prev;
		logic                 app_limited;
	} drs_slot_t;

	typedef struct packed {
		logic                 start;
		logic [BYTE_BITS-1:0] bytes;
		logic [TIME_BITS-1:0] us;
	} drs_div_req_t;

endpackage

[rtl/drs_div.sv]
// rate divider: floor(bytes * 8e6 / us), saturated, one quotient bit per cycle
// depends on drs_pkg
module drs_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  drs_pkg::drs_div_req_t               req,
	output logic                                done,
	output logic [drs_pkg::RATE_BITS-1:0]       quot
);
	import drs_pkg::*;

	typedef enum logic [3:0] {
		D_IDLE = 4'b0001,
		D_MUL  = 4'b0010,
		D_LOAD = 4'b0100,
		D_RUN  = 4'b1000
	} dstate_t;

	dstate_t              state_q;
	logic [BYTE_BITS-1:0] bytes_q;
	logic [TIME_BITS-1:0] us_q;
	logic [PROD_BITS-1:0] prod_q;
	logic [RATE_BITS-1:0] rem_q;
	logic [RATE_BITS-1:0] lo_q;
	logic [RATE_BITS-1:0] q_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 done_q;

	logic [DIVD_BITS-1:0] dividend;
	logic [RATE_BITS-1:0] us_w;
	logic [RATE_BITS-1:0] shifted;
	logic                 ge;

	assign dividend = {prod_q, {RATE_SHIFT{1'b0}}};
	assign us_w     = RATE_BITS'(us_q);
	assign shifted  = {rem_q[RATE_BITS-2:0], lo_q[RATE_BITS-1]};
	assign ge       = rem_q[RATE_BITS-1] || (shifted >= us_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (req.start) begin
						state_q <= D_MUL;
					end
				end
				D_MUL: begin
					state_q <= D_LOAD;
				end
				D_LOAD: begin
					if (RATE_BITS'(dividend[DIVD_BITS-1:RATE_BITS]) >= us_w) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end else begin
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					if (cnt_q == '0) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				bytes_q <= req.bytes;
				us_q    <= req.us;
			end
			D_MUL: begin
				prod_q <= PROD_BITS'(bytes_q) * PROD_BITS'(BIT_RATE_MULT);
			end
			D_LOAD: begin
				rem_q <= RATE_BITS'(dividend[DIVD_BITS-1:RATE_BITS]);
				lo_q  <= dividend[RATE_BITS-1:0];
				q_q   <= RATE_MAX;
				cnt_q <= CNT_BITS'(RATE_BITS - 1);
			end
			D_RUN: begin
				rem_q <= ge ? shifted - us_w : shifted;
				lo_q  <= {lo_q[RATE_BITS-2:0], 1'b0};
				q_q   <= {q_q[RATE_BITS-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign quot = (q_q == RATE_INF) ? RATE_MAX : q_q;

endmodule

[rtl/delivery_rate_sampler.sv]
// Delivery rate sampler: one result word per event word. A send, an ack or loss of an
// untracked packet, an app-limited mark or an unused code goes from exec straight to
// finish. An ack that yields a sample runs one or two bit-serial divisions (send rate,
// if the send interval is positive, then ack rate) on one shared divider; releasing the
// oldest tracked packet then walks the valid bits one slot per cycle, and a drop-older-than
// event walks over every slot it frees. Slot snapshots live in one synchronous memory of
// 256 words; valid bits are flops cleared by reset.
// depends on drs_pkg and drs_div
module delivery_rate_sampler (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  drs_pkg::drs_in_t  req_word,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output drs_pkg::drs_out_t rsp_word
);
	import drs_pkg::*;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b000000000001,
		ST_EXEC = 12'b000000000010,
		ST_ACK  = 12'b000000000100,
		ST_DSS  = 12'b000000001000,
		ST_DSW  = 12'b000000010000,
		ST_DAS  = 12'b000000100000,
		ST_DAW  = 12'b000001000000,
		ST_REL  = 12'b000010000000,
		ST_WALK = 12'b000100000000,
		ST_DROP = 12'b001000000000,
		ST_FIN  = 12'b010000000000,
		ST_SPARE = 12'b100000000000
	} state_t;

	state_t               state_q;
	drs_in_t              in_q;
	drs_out_t             rsp_q;
	logic                 rsp_valid_q;

	drs_slot_t            slot_mem [TRACK_DEPTH];
	drs_slot_t            rd_q;
	logic [TRACK_DEPTH-1:0] slot_valid_q;

	logic [BYTE_BITS-1:0] sent_total_q;
	logic [BYTE_BITS-1:0] acked_total_q;
	logic [BYTE_BITS-1:0] sent_at_ack_q;
	logic [TIME_BITS-1:0] prev_sent_q;
	logic [TIME_BITS-1:0] prev_ack_q;
	logic [NUM_BITS-1:0]  newest_sent_q;
	logic                 app_flag_q;
	logic [NUM_BITS-1:0]  app_last_q;
	logic [NUM_BITS-1:0]  oldest_q;
	logic [NUM_BITS-1:0]  newest_q;
	logic                 nonempty_q;
	logic                 ret_drop_q;

	logic                 res_valid_q;
	logic [RATE_BITS-1:0] bw_q;
	logic [TIME_BITS-1:0] rtt_q;
	logic                 res_app_q;
	logic                 refused_q;
	logic [RATE_BITS-1:0] tx_rate_q;
	logic [BYTE_BITS-1:0] sbytes_q;
	logic [TIME_BITS-1:0] sus_q;
	logic [BYTE_BITS-1:0] abytes_q;
	logic [TIME_BITS-1:0] aus_q;

	drs_div_req_t         div_req;
	logic                 div_done;
	logic [RATE_BITS-1:0] div_quot;

	logic [SLOT_BITS-1:0] slot;
	logic                 tracked;
	logic [BYTE_BITS-1:0] snt_total;
	logic                 idle_send;
	logic                 send_ok;
	drs_slot_t            wr_slot;
	logic [BYTE_BITS-1:0] acked_new;
	logic [NUM_BITS-1:0]  oldest_inc;
	state_t               ret_state;

	assign slot      = in_q.pkt_num[SLOT_BITS-1:0];
	assign tracked   = nonempty_q && (in_q.pkt_num >= oldest_q) &&
	                   (in_q.pkt_num <= newest_q) && slot_valid_q[slot];
	assign snt_total = sent_total_q + BYTE_BITS'(in_q.packet_bytes);
	assign idle_send = (in_q.flight_bytes == '0);
	assign send_ok   = !nonempty_q || ((in_q.pkt_num > newest_q) &&
	                   ((in_q.pkt_num - oldest_q) < NUM_BITS'(TRACK_DEPTH)));
	assign acked_new = acked_total_q + BYTE_BITS'(rd_q.size);
	assign oldest_inc = oldest_q + 1'b1;
	assign ret_state = ret_drop_q ? ST_DROP : ST_FIN;

	always_comb begin
		wr_slot.tx_time          = in_q.event_time;
		wr_slot.size             = in_q.packet_bytes;
		wr_slot.bytes_sent       = snt_total;
		wr_slot.bytes_sent_prev  = idle_send ? snt_total : sent_at_ack_q;
		wr_slot.prev_sent_time   = idle_send ? in_q.event_time : prev_sent_q;
		wr_slot.prev_ack_time    = idle_send ? in_q.event_time : prev_ack_q;
		wr_slot.bytes_acked_prev = acked_total_q;
		wr_slot.app_limited      = app_flag_q;
	end

	always_comb begin
		div_req.start = (state_q == ST_DSS) || (state_q == ST_DAS);
		div_req.bytes = (state_q == ST_DSS) ? sbytes_q : abytes_q;
		div_req.us    = (state_q == ST_DSS) ? sus_q : aus_q;
	end

	drs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	// slot memory
	always_ff @(posedge clk) begin
		if ((state_q == ST_EXEC) && (in_q.operation == OP_SENT) && send_ok) begin
			slot_mem[slot] <= wr_slot;
		end
		rd_q <= slot_mem[slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rsp_valid_q   <= 1'b0;
			slot_valid_q  <= '0;
			sent_total_q  <= '0;
			acked_total_q <= '0;
			sent_at_ack_q <= '0;
			prev_sent_q   <= '0;
			prev_ack_q    <= '0;
			newest_sent_q <= '0;
			app_flag_q    <= 1'b0;
			app_last_q    <= '0;
			oldest_q      <= '0;
			newest_q      <= '0;
			nonempty_q    <= 1'b0;
			ret_drop_q    <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					ret_drop_q <= 1'b0;
					case (in_q.operation)
						OP_SENT: begin
							newest_sent_q <= in_q.pkt_num;
							sent_total_q  <= snt_total;
							if (idle_send) begin
								prev_ack_q    <= in_q.event_time;
								prev_sent_q   <= in_q.event_time;
								sent_at_ack_q <= snt_total;
							end
							if (!nonempty_q) begin
								nonempty_q <= 1'b1;
								oldest_q   <= in_q.pkt_num;
							end
							if (send_ok) begin
								newest_q           <= in_q.pkt_num;
								slot_valid_q[slot] <= 1'b1;
							end
							state_q <= ST_FIN;
						end
						OP_ACKED: state_q <= tracked ? ST_ACK : ST_FIN;
						OP_LOST:  state_q <= tracked ? ST_REL : ST_FIN;
						OP_APP: begin
							app_flag_q <= 1'b1;
							app_last_q <= newest_sent_q;
							state_q    <= ST_FIN;
						end
						OP_DROP: state_q <= ST_DROP;
						default: state_q <= ST_FIN;
					endcase
				end
				ST_ACK: begin
					acked_total_q <= acked_new;
					sent_at_ack_q <= rd_q.bytes_sent;
					prev_sent_q   <= rd_q.tx_time;
					prev_ack_q    <= in_q.event_time;
					if (app_flag_q && (in_q.pkt_num > app_last_q)) begin
						app_flag_q <= 1'b0;
					end
					if ((rd_q.prev_sent_time != '0) &&
					    (in_q.event_time > rd_q.prev_ack_time)) begin
						state_q <= (rd_q.tx_time > rd_q.prev_sent_time) ?
						           ST_DSS : ST_DAS;
					end else begin
						state_q <= ST_REL;
					end
				end
				ST_DSS: state_q <= ST_DSW;
				ST_DSW: begin
					if (div_done) begin
						state_q <= ST_DAS;
					end
				end
				ST_DAS: state_q <= ST_DAW;
				ST_DAW: begin
					if (div_done) begin
						state_q <= ST_REL;
					end
				end
				ST_REL: begin
					slot_valid_q[slot] <= 1'b0;
					state_q <= (in_q.pkt_num == oldest_q) ? ST_WALK : ST_FIN;
				end
				ST_WALK: begin
					if (oldest_q >= newest_q) begin
						nonempty_q <= 1'b0;
						state_q    <= ret_state;
					end else begin
						oldest_q <= oldest_inc;
						if (slot_valid_q[oldest_inc[SLOT_BITS-1:0]]) begin
							state_q <= ret_state;
						end
					end
				end
				ST_DROP: begin
					ret_drop_q <= 1'b1;
					if (nonempty_q && (oldest_q < in_q.pkt_num)) begin
						slot_valid_q[oldest_q[SLOT_BITS-1:0]] <= 1'b0;
						state_q <= ST_WALK;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				in_q        <= req_word;
				res_valid_q <= 1'b0;
				bw_q        <= '0;
				rtt_q       <= '0;
				res_app_q   <= 1'b0;
				refused_q   <= 1'b0;
			end
			ST_EXEC: begin
				if (in_q.operation == OP_SENT) begin
					refused_q <= !send_ok;
				end
			end
			ST_ACK: begin
				sbytes_q    <= rd_q.bytes_sent - rd_q.bytes_sent_prev;
				sus_q       <= rd_q.tx_time - rd_q.prev_sent_time;
				abytes_q    <= acked_new - rd_q.bytes_acked_prev;
				aus_q       <= in_q.event_time - rd_q.prev_ack_time;
				tx_rate_q   <= RATE_INF;
				if ((rd_q.prev_sent_time != '0) &&
				    (in_q.event_time > rd_q.prev_ack_time)) begin
					res_valid_q <= 1'b1;
					rtt_q       <= in_q.event_time - rd_q.tx_time;
					res_app_q   <= rd_q.app_limited;
				end
			end
			ST_DSW: begin
				if (div_done) begin
					tx_rate_q <= div_quot;
				end
			end
			ST_DAW: begin
				if (div_done) begin
					bw_q <= (tx_rate_q < div_quot) ? tx_rate_q : div_quot;
				end
			end
			ST_FIN: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_q.sample_valid       <= res_valid_q;
					rsp_q.bandwidth_bps      <= bw_q;
					rsp_q.rtt_us             <= rtt_q;
					rsp_q.sample_app_limited <= res_app_q;
					rsp_q.total_acked        <= acked_total_q;
					rsp_q.app_limited_now    <= app_flag_q;
					rsp_q.app_limited_end    <= app_last_q;
					rsp_q.refused            <= refused_q;
				end
			end
			default: ;
		endcase
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

	a_empty_no_slots: assert property (@(posedge clk) disable iff (!arst_n)
		!nonempty_q |-> (slot_valid_q == '0))
		else $error("valid slot held while table empty");

	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		nonempty_q |-> ((newest_q - oldest_q) < NUM_BITS'(TRACK_DEPTH)))
		else $error("tracked span exceeds ring depth");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> ((state_q == ST_DSW) || (state_q == ST_DAW)))
		else $error("divider finished outside a wait state");

endmodule
